>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the free list allocator RTL
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge of clk.
`define FBFL_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define FBFL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/fbfl_pkg.sv
// ----------------------------------------------------------------------------
// fbfl_pkg
// Types and constants for the fixed block free list allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package fbfl_pkg;

  localparam int MAX_BLOCKS = 1024;
  localparam int MIN_BLOCKS = 1;
  localparam int IDX_W      = $clog2(MAX_BLOCKS);
  localparam int CNT_W      = IDX_W + 1;

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BLOCKS);
  localparam logic [CNT_W-1:0] CNT_MIN = CNT_W'(MIN_BLOCKS);

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_FULL      = 2'd1;
  localparam logic [1:0] STATUS_BAD_INDEX = 2'd2;

  typedef struct packed {
    logic             opcode;
    logic [IDX_W-1:0] block_index;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [IDX_W-1:0] given_index;
    logic [CNT_W-1:0] used_blocks;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_EXEC
  } fbfl_state_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;      // latch the incoming transaction
    logic commit;      // apply the request and load the output register
    logic cfg_write;   // take the block count write
    logic sweep_step;  // relink one entry of the link store
  } fbfl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic sweep_done;
    logic cfg_change;
    logic out_free;
  } fbfl_sts_t;

endpackage

`default_nettype wire

>>> rtl/fbfl_ctrl.sv
// ----------------------------------------------------------------------------
// fbfl_ctrl
// Sequencer: relink sweep, request intake and commit, config handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module fbfl_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              cfg_valid,
  input  wire fbfl_pkg::fbfl_sts_t sts,
  output fbfl_pkg::fbfl_cmd_t    cmd,
  output logic                   in_stall,
  output logic                   cfg_ready
);

  fbfl_pkg::fbfl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fbfl_pkg::ST_SWEEP;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    in_stall       = 1'b1;
    cfg_ready      = 1'b0;
    case (state_r)
      fbfl_pkg::ST_SWEEP: begin
        if (sts.sweep_done) begin
          state_nxt = fbfl_pkg::ST_IDLE;
        end else begin
          cmd.sweep_step = 1'b1;
        end
      end
      fbfl_pkg::ST_IDLE: begin
        in_stall  = 1'b0;
        // requests win over a config write in the same cycle
        cfg_ready = !in_valid;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = fbfl_pkg::ST_EXEC;
        end else if (cfg_valid) begin
          cmd.cfg_write = 1'b1;
          if (sts.cfg_change) begin
            state_nxt = fbfl_pkg::ST_SWEEP;
          end
        end
      end
      fbfl_pkg::ST_EXEC: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = fbfl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = fbfl_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/fbfl_dpath.sv
// ----------------------------------------------------------------------------
// fbfl_dpath
// Link store, head and count registers, relink sweep pointer, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module fbfl_dpath (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire fbfl_pkg::fbfl_cmd_t             cmd,
  input  wire fbfl_pkg::in_item_t              in_data,
  input  wire logic [fbfl_pkg::CNT_W-1:0]      cfg_data,
  input  wire logic                            out_stall,
  output fbfl_pkg::fbfl_sts_t                  sts,
  output logic                                 out_valid,
  output fbfl_pkg::out_item_t                  out_data
);

  localparam int IW = fbfl_pkg::IDX_W;
  localparam int CW = fbfl_pkg::CNT_W;

  logic [CW-1:0] link_mem [fbfl_pkg::MAX_BLOCKS];

  logic [CW-1:0]       bc_r, head_r, used_r, ptr_r, end_r;
  logic [CW-1:0]       head_nxt, used_nxt;
  logic [CW-1:0]       rdata_r;
  fbfl_pkg::in_item_t  item_r;
  logic                out_valid_r;
  fbfl_pkg::out_item_t out_r, res;

  logic [CW-1:0] cfg_want;
  logic [CW-1:0] free_idx;
  logic          alloc_ok, free_ok;
  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  logic [CW-1:0] mem_wdata;

  always_comb begin
    if (cfg_data < fbfl_pkg::CNT_MIN) begin
      cfg_want = fbfl_pkg::CNT_MIN;
    end else if (cfg_data > fbfl_pkg::CNT_MAX) begin
      cfg_want = fbfl_pkg::CNT_MAX;
    end else begin
      cfg_want = cfg_data;
    end
  end

  assign free_idx = {1'b0, item_r.block_index};
  // head at or past block_count covers a pool that shrank under the head
  assign alloc_ok = (used_r < bc_r) && (head_r < bc_r);
  assign free_ok  = (free_idx < bc_r) && (used_r != '0);

  always_comb begin
    head_nxt        = head_r;
    used_nxt        = used_r;
    res.status      = fbfl_pkg::STATUS_OK;
    res.given_index = '0;
    if (item_r.opcode == fbfl_pkg::OP_ALLOC) begin
      if (alloc_ok) begin
        res.given_index = head_r[IW-1:0];
        head_nxt        = rdata_r;
        used_nxt        = used_r + CW'(1);
      end else begin
        res.status = fbfl_pkg::STATUS_FULL;
      end
    end else begin
      if (free_ok) begin
        head_nxt = free_idx;
        used_nxt = used_r - CW'(1);
      end else begin
        res.status = fbfl_pkg::STATUS_BAD_INDEX;
      end
    end
    res.used_blocks = used_nxt;
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = ptr_r[IW-1:0];
    mem_wdata = ptr_r + CW'(1);
    if (cmd.sweep_step) begin
      mem_we = 1'b1;
    end else if (cmd.commit && item_r.opcode == fbfl_pkg::OP_FREE && free_ok) begin
      mem_we    = 1'b1;
      mem_waddr = item_r.block_index;
      mem_wdata = head_r;
    end
  end

  // head is stable from the accept edge on, so rdata_r holds its link in EXEC
  always_ff @(posedge clk) begin
    if (mem_we) begin
      link_mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= link_mem[head_r[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bc_r        <= fbfl_pkg::CNT_MAX;
      head_r      <= '0;
      used_r      <= '0;
      ptr_r       <= '0;
      end_r       <= fbfl_pkg::CNT_MAX;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.cfg_write && sts.cfg_change) begin
        bc_r  <= cfg_want;
        ptr_r <= used_r;
        end_r <= cfg_want;
      end else if (cmd.sweep_step) begin
        ptr_r <= ptr_r + CW'(1);
      end
      if (cmd.commit) begin
        head_r      <= head_nxt;
        used_r      <= used_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_r <= in_data;
    end
    if (cmd.commit) begin
      out_r <= res;
    end
  end

  assign sts.sweep_done = (ptr_r >= end_r);
  assign sts.cfg_change = (cfg_want != bc_r);
  assign sts.out_free   = !out_valid_r || !out_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

>>> rtl/fixed_block_free_list_core.sv
// ----------------------------------------------------------------------------
// fixed_block_free_list_core
// Fixed-size block pool allocator built on a free list in a link store.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_stall/in_data: opcode allocate or free, plus the
// block index to free. Each transaction gives exactly one result on
// out_valid/out_stall/out_data: status, allocated index, used block count.
// The result register is loaded when the taken request commits from the execute
// state. A new request is taken only after the last one has committed: an
// allocate reads the link at the head into a register and then moves the head
// to it, through the single-read-port link store.
// A stalled result holds in the output register; the request taken behind it
// waits in the execute state and is committed once the register frees up.
// cfg_valid/cfg_ready/cfg_data writes block_count (clamped to 1..1024).
// Reset sweeps the link store with in_stall high and cfg_ready low, writing
// all 1024 entries before it leaves the sweep. A block_count write that
// changes the value relinks entries from the used count up to the new count,
// one per cycle, and none when the new count is at or below the used count.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module fixed_block_free_list_core (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire fbfl_pkg::in_item_t          in_data,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output fbfl_pkg::out_item_t              out_data,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [fbfl_pkg::CNT_W-1:0]  cfg_data
);

  fbfl_pkg::fbfl_cmd_t cmd;
  fbfl_pkg::fbfl_sts_t sts;

  fbfl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .cfg_valid (cfg_valid),
    .sts       (sts),
    .cmd       (cmd),
    .in_stall  (in_stall),
    .cfg_ready (cfg_ready)
  );

  fbfl_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .cfg_data  (cfg_data),
    .out_stall (out_stall),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // one transaction in flight at a time
  `FBFL_ASSERT_NEXT(a_one_in_flight, in_valid && !in_stall, in_stall, "second transaction taken while busy")
  // config is never written in the cycle a request is taken
  `FBFL_ASSERT_IMPL(a_cfg_vs_req, in_valid && !in_stall, !cfg_ready, "config write collides with request")
  `FBFL_ASSERT_IMPL(a_given_zero, out_valid && out_data.status != fbfl_pkg::STATUS_OK, out_data.given_index == '0, "given index set on failed request")
  `FBFL_ASSERT_IMPL(a_used_bound, out_valid, out_data.used_blocks <= fbfl_pkg::CNT_MAX, "used count beyond pool size")

endmodule

`default_nettype wire
